// ===== hw/rtl/dtnf_pkg.sv =====
// Shared types and codes for the device tree node name finder.
`default_nettype none

package dtnf_pkg;

  // Result codes carried on event_res.
  localparam logic [1:0] EV_MATCH    = 2'd0;
  localparam logic [1:0] EV_END      = 2'd1;
  localparam logic [1:0] EV_UNKNOWN  = 2'd2;
  localparam logic [1:0] EV_OVERFLOW = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_QUERY_LEN     = 3'd0;
  localparam logic [2:0] REG_QUERY_CHARS_0 = 3'd1;
  localparam logic [2:0] REG_QUERY_CHARS_1 = 3'd2;
  localparam logic [2:0] REG_QUERY_CHARS_2 = 3'd3;
  localparam logic [2:0] REG_QUERY_CHARS_3 = 3'd4;

  typedef logic [23:0] offset_t;

  typedef struct packed {
    logic [5:0]       len;
    logic [31:0][7:0] chars;
  } query_t;

  typedef struct packed {
    logic [1:0] event_res;
    offset_t    node_offset;
    logic       scan_last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtnf_cfg.sv =====
// Query name configuration registers.
`default_nettype none

module dtnf_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [63:0]    cfg_data,
  output dtnf_pkg::query_t    query
);

  logic [5:0]  query_len;
  logic [63:0] chars_0;
  logic [63:0] chars_1;
  logic [63:0] chars_2;
  logic [63:0] chars_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_len <= '0;
      chars_0   <= '0;
      chars_1   <= '0;
      chars_2   <= '0;
      chars_3   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtnf_pkg::REG_QUERY_LEN:     query_len <= cfg_data[5:0];
        dtnf_pkg::REG_QUERY_CHARS_0: chars_0   <= cfg_data;
        dtnf_pkg::REG_QUERY_CHARS_1: chars_1   <= cfg_data;
        dtnf_pkg::REG_QUERY_CHARS_2: chars_2   <= cfg_data;
        dtnf_pkg::REG_QUERY_CHARS_3: chars_3   <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  assign query.len   = query_len;
  assign query.chars = {chars_3, chars_2, chars_1, chars_0};

endmodule

`default_nettype wire

// ===== hw/rtl/dtnf_parser.sv =====
// Structure block parser: token assembly, skipping and name compare.
`default_nettype none

module dtnf_parser #(
  parameter int MAX_NAME     = 32,
  parameter int OFFSET_WIDTH = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic [7:0]     byte_in,
  input  wire dtnf_pkg::query_t query,
  output logic                res_valid,
  output dtnf_pkg::result_t   res
);

  localparam int NIW = $clog2(MAX_NAME + 1);
  localparam logic [5:0] MaxLen = 6'(MAX_NAME);
  localparam logic [OFFSET_WIDTH-1:0] PosLast = '1;

  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_AT  = 8'h40;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_NAME, PH_ALIGN, PH_PLEN, PH_PNAMEOFF, PH_PDATA
  } phase_t;

  phase_t                  parse_phase, parse_phase_next;
  logic [OFFSET_WIDTH-1:0] byte_position, byte_position_next;
  logic [31:0]             word_shift, word_shift_next;
  logic [1:0]              word_byte_index, word_byte_index_next;
  logic [NIW-1:0]          name_index, name_index_next;
  logic                    name_mismatch, name_mismatch_next;
  logic                    name_ended, name_ended_next;
  logic [31:0]             skip_remaining, skip_remaining_next;
  logic [OFFSET_WIDTH-1:0] node_start, node_start_next;
  logic                    scan_finished, scan_finished_next;
  logic                    hit_next;
  dtnf_pkg::result_t       res_next;

  logic [5:0]              eff_len;
  logic [OFFSET_WIDTH-1:0] tok_off;
  logic [31:0]             word_in;
  logic                    word_done;
  phase_t                  pad_phase;
  logic                    name_term;
  logic [7:0]              q_byte;
  logic [31:0]             skip_dec;

  assign eff_len   = (query.len > MaxLen) ? MaxLen : query.len;
  assign tok_off   = {byte_position[OFFSET_WIDTH-1:2], 2'b00};
  assign word_in   = {word_shift[23:0], byte_in};
  assign word_done = (word_byte_index == 2'd3);
  // Back to token reads once the byte just taken closes an aligned word.
  assign pad_phase = (byte_position[1:0] == 2'd3) ? PH_TOKEN : PH_ALIGN;
  assign name_term = (byte_in == CHAR_NUL) || (byte_in == CHAR_AT);
  assign q_byte    = query.chars[5'(name_index)];
  assign skip_dec  = skip_remaining - 32'd1;

  always_comb begin
    parse_phase_next     = parse_phase;
    byte_position_next   = byte_position;
    word_shift_next      = word_shift;
    word_byte_index_next = word_byte_index;
    name_index_next      = name_index;
    name_mismatch_next   = name_mismatch;
    name_ended_next      = name_ended;
    skip_remaining_next  = skip_remaining;
    node_start_next      = node_start;
    scan_finished_next   = scan_finished;
    hit_next             = 1'b0;
    res_next.event_res   = dtnf_pkg::EV_MATCH;
    res_next.node_offset = dtnf_pkg::offset_t'(tok_off);
    res_next.scan_last   = 1'b1;

    if (!scan_finished) begin
      if (byte_position == PosLast) begin
        scan_finished_next   = 1'b1;
        hit_next             = 1'b1;
        res_next.event_res   = dtnf_pkg::EV_OVERFLOW;
        res_next.node_offset = dtnf_pkg::offset_t'(byte_position);
      end else begin
        byte_position_next = byte_position + 1'b1;
        unique case (parse_phase)
          PH_TOKEN, PH_PLEN, PH_PNAMEOFF: begin
            word_shift_next      = word_in;
            word_byte_index_next = word_byte_index + 2'd1;
            if (word_done) begin
              if (parse_phase == PH_PLEN) begin
                skip_remaining_next = word_in;
                parse_phase_next    = PH_PNAMEOFF;
              end else if (parse_phase == PH_PNAMEOFF) begin
                parse_phase_next = (skip_remaining == '0) ? PH_TOKEN : PH_PDATA;
              end else begin
                priority if (word_in == TOK_BEGIN_NODE) begin
                  node_start_next    = tok_off;
                  name_index_next    = '0;
                  name_mismatch_next = 1'b0;
                  name_ended_next    = 1'b0;
                  parse_phase_next   = PH_NAME;
                end else if (word_in == TOK_END_NODE || word_in == TOK_NOP) begin
                  parse_phase_next = PH_TOKEN;
                end else if (word_in == TOK_PROP) begin
                  parse_phase_next = PH_PLEN;
                end else if (word_in == TOK_END) begin
                  scan_finished_next = 1'b1;
                  hit_next           = 1'b1;
                  res_next.event_res = dtnf_pkg::EV_END;
                end else begin
                  scan_finished_next = 1'b1;
                  hit_next           = 1'b1;
                  res_next.event_res = dtnf_pkg::EV_UNKNOWN;
                end
              end
            end
          end
          PH_NAME: begin
            if (!name_ended && name_term) begin
              name_ended_next = 1'b1;
              if (!name_mismatch && 6'(name_index) == eff_len) begin
                hit_next             = 1'b1;
                res_next.event_res   = dtnf_pkg::EV_MATCH;
                res_next.node_offset = dtnf_pkg::offset_t'(node_start);
                res_next.scan_last   = 1'b0;
              end
            end else if (!name_ended && !name_mismatch) begin
              if (6'(name_index) < eff_len && byte_in == q_byte)
                name_index_next = name_index + 1'b1;
              else
                name_mismatch_next = 1'b1;
            end
            if (byte_in == CHAR_NUL) parse_phase_next = pad_phase;
          end
          PH_ALIGN: begin
            parse_phase_next = pad_phase;
          end
          PH_PDATA: begin
            skip_remaining_next = skip_dec;
            if (skip_dec == '0) parse_phase_next = pad_phase;
          end
          default: begin
            parse_phase_next = PH_TOKEN;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_TOKEN;
      byte_position   <= '0;
      word_shift      <= '0;
      word_byte_index <= '0;
      name_index      <= '0;
      name_mismatch   <= 1'b0;
      name_ended      <= 1'b0;
      skip_remaining  <= '0;
      node_start      <= '0;
      scan_finished   <= 1'b0;
    end else if (step) begin
      parse_phase     <= parse_phase_next;
      byte_position   <= byte_position_next;
      word_shift      <= word_shift_next;
      word_byte_index <= word_byte_index_next;
      name_index      <= name_index_next;
      name_mismatch   <= name_mismatch_next;
      name_ended      <= name_ended_next;
      skip_remaining  <= skip_remaining_next;
      node_start      <= node_start_next;
      scan_finished   <= scan_finished_next;
    end
  end

  assign res_valid = hit_next;
  assign res       = res_next;

endmodule

`default_nettype wire

// ===== hw/rtl/device_tree_node_name_finder.sv =====
// Top level of the device tree node name finder.
// Throughput: one byte word per cycle unless event_ready stalls the result
// register; the parse step is a single compare and counter update between
// the input register and the result register.
// Reset: parse state, byte offset and query registers clear; the scan
// restarts at offset 0 and both pipeline registers empty.
`default_nettype none

module device_tree_node_name_finder #(
  parameter int MAX_NAME     = 32,
  parameter int OFFSET_WIDTH = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // structure block byte stream
  input  wire logic        blob_valid,
  output logic             blob_ready,
  input  wire logic [7:0]  blob_byte,
  // result stream
  output logic             event_valid,
  input  wire logic        event_ready,
  output logic [1:0]       event_res,
  output logic [23:0]      node_offset,
  output logic             scan_last,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // Input register: holds one byte word until the parser can take it.
  logic        in_full;
  logic [7:0]  in_byte;

  // Result register.
  logic              out_full;
  dtnf_pkg::result_t out_word;

  logic              out_free;
  logic              advance;
  logic              res_valid;
  dtnf_pkg::result_t res;
  dtnf_pkg::query_t  query;

  // The parser consumes the held byte whenever the result register can
  // accept whatever the byte produces (it may produce nothing).
  assign out_free   = !out_full || event_ready;
  assign advance    = in_full && out_free;
  assign blob_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (blob_ready) begin
      in_full <= blob_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blob_valid && blob_ready) begin
      in_byte <= blob_byte;
    end
  end

  dtnf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (query)
  );

  dtnf_parser #(
    .MAX_NAME     (MAX_NAME),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_in   (in_byte),
    .query     (query),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: loads on each parser step that gives a result, drains on acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= res_valid;
    end else if (event_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word <= res;
    end
  end

  assign event_valid = out_full;
  assign event_res   = out_word.event_res;
  assign node_offset = out_word.node_offset;
  assign scan_last   = out_word.scan_last;

  // Only a match leaves the scan running.
  a_last_code: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (scan_last == (event_res != dtnf_pkg::EV_MATCH)))
    else $error("scan_last disagrees with result code");

  // Once the ending word is taken, nothing follows until reset.
  a_nothing_after_last: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_ready && scan_last) |=> !event_valid)
    else $error("result word after end of scan");

  // Matches always point at an aligned BEGIN_NODE token.
  a_match_aligned: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_res == dtnf_pkg::EV_MATCH) |-> (node_offset[1:0] == 2'b00))
    else $error("unaligned match offset");

endmodule

`default_nettype wire
